FILE: design/lsst_pkg.sv
// package: types, widths and constants for the line segment similarity test
package lsst_pkg;

  localparam int COORD_BITS = 12;
  localparam int LEN_BITS   = 2 * COORD_BITS + 1;
  localparam int Q_BITS     = 20;
  localparam logic [Q_BITS-1:0] COS2_Q20 = 20'd1037119;
  localparam int NEAR_SCALE = 100;
  localparam int MID_SCALE  = 25;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    RULE_NEAR  = 2'd0,
    RULE_ANGLE = 2'd1,
    RULE_FAR   = 2'd2,
    RULE_PASS  = 2'd3
  } rule_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic  similar;
    rule_t deciding_rule;
  } sim_res_t;

  typedef logic signed [COORD_BITS:0] diff_t;
  typedef logic [LEN_BITS-1:0]        len_t;

  function automatic diff_t sub_c(input coord_t p, input coord_t q);
    return $signed({1'b0, p}) - $signed({1'b0, q});
  endfunction

  function automatic len_t sq_sum(input diff_t a, input diff_t b);
    logic signed [2*COORD_BITS+1:0] pa;
    logic signed [2*COORD_BITS+1:0] pb;
    pa = a * a;
    pb = b * b;
    return {1'b0, pa[2*COORD_BITS-1:0]} + {1'b0, pb[2*COORD_BITS-1:0]};
  endfunction

endpackage

FILE: design/line_segment_similarity_test.sv
// top level: pipelined line segment similarity test
// throughput: one segment pair per cycle, busy is never raised
// the multiplier chain of the angle test sets the pipeline depth
// the receiver cannot stall, so results leave on fixed cycles
// synchronous active-low reset clears only the stage valid bits
module line_segment_similarity_test
  import lsst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  seg_pair_t in_seg,
  output logic      out_valid,
  output sim_res_t  out_res
);

  localparam int W    = COORD_BITS;
  localparam int L    = LEN_BITS;
  localparam int SW   = 2 * W + 3;
  localparam int D1W  = L + 7;
  localparam int S25W = SW + 5;
  localparam int PW   = 2 * L;
  localparam int QW   = 2 * L + Q_BITS;
  localparam int HW   = L + Q_BITS;

  logic [5:0] v_r;
  logic [5:0] v_nxt;

  // stage 1: coordinate differences and endpoint sum differences
  diff_t dxa_r, dya_r, dxb_r, dyb_r;
  diff_t dxa_nxt, dya_nxt, dxb_nxt, dyb_nxt;
  diff_t ex_r [4];
  diff_t ey_r [4];
  diff_t ex_nxt [4];
  diff_t ey_nxt [4];
  logic signed [W+1:0] sx_r, sy_r, sx_nxt, sy_nxt;

  // stage 2: squared lengths and endpoint distances, dot product, squared midpoint offset
  len_t len1_r, len2_r, len1_nxt, len2_nxt;
  len_t d_r [4];
  len_t d_nxt [4];
  logic signed [2*W+1:0] dot_r, dot_nxt;
  logic [SW-1:0] s_r, s_nxt;

  // stage 3: near, far and zero-length flags, operands of the angle test
  logic near3_r, far3_r, zero3_r, near3_nxt, far3_nxt, zero3_nxt;
  len_t adot_r, l1_3_r, l2_3_r, adot_nxt;

  // stage 4: products
  logic near4_r, far4_r, zero4_r;
  logic [PW-1:0] dsq_r, lp_r, dsq_nxt, lp_nxt;

  // stage 5: scaling by the squared cosine constant
  logic near5_r, far5_r, zero5_r;
  logic [PW-1:0] dsq5_r;
  logic [HW-1:0] qlo_r, qhi_r, qlo_nxt, qhi_nxt;

  // stage 6: angle comparison, rule priority, output register
  sim_res_t res_r, res_nxt;
  logic [QW-1:0] lhs6, rhs6;
  logic angle_lt;

  assign busy = 1'b0;

  always_comb begin
    dxa_nxt = sub_c(in_seg.a_end_x, in_seg.a_start_x);
    dya_nxt = sub_c(in_seg.a_end_y, in_seg.a_start_y);
    dxb_nxt = sub_c(in_seg.b_end_x, in_seg.b_start_x);
    dyb_nxt = sub_c(in_seg.b_end_y, in_seg.b_start_y);
    ex_nxt[0] = sub_c(in_seg.b_start_x, in_seg.a_start_x);
    ey_nxt[0] = sub_c(in_seg.b_start_y, in_seg.a_start_y);
    ex_nxt[1] = sub_c(in_seg.b_end_x, in_seg.a_start_x);
    ey_nxt[1] = sub_c(in_seg.b_end_y, in_seg.a_start_y);
    ex_nxt[2] = sub_c(in_seg.b_start_x, in_seg.a_end_x);
    ey_nxt[2] = sub_c(in_seg.b_start_y, in_seg.a_end_y);
    ex_nxt[3] = sub_c(in_seg.b_end_x, in_seg.a_end_x);
    ey_nxt[3] = sub_c(in_seg.b_end_y, in_seg.a_end_y);
    sx_nxt = $signed({2'b00, in_seg.a_start_x} + {2'b00, in_seg.a_end_x})
           - $signed({2'b00, in_seg.b_start_x} + {2'b00, in_seg.b_end_x});
    sy_nxt = $signed({2'b00, in_seg.a_start_y} + {2'b00, in_seg.a_end_y})
           - $signed({2'b00, in_seg.b_start_y} + {2'b00, in_seg.b_end_y});
  end

  always_comb begin
    logic signed [2*W+3:0] qx, qy;
    logic signed [2*W+1:0] px, py;
    len1_nxt = sq_sum(dxa_r, dya_r);
    len2_nxt = sq_sum(dxb_r, dyb_r);
    for (int k = 0; k < 4; k++) begin
      d_nxt[k] = sq_sum(ex_r[k], ey_r[k]);
    end
    px = dxa_r * dxb_r;
    py = dya_r * dyb_r;
    dot_nxt = px + py;
    qx = sx_r * sx_r;
    qy = sy_r * sy_r;
    s_nxt = SW'(qx) + SW'(qy);
  end

  always_comb begin
    len_t mx;
    logic [D1W-1:0] d100;
    logic [S25W-1:0] s25;
    near3_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      d100 = D1W'(d_r[k]) * D1W'(NEAR_SCALE);
      if (d100 <= D1W'(len1_r)) begin
        near3_nxt = 1'b1;
      end
    end
    mx = (len1_r > len2_r) ? len1_r : len2_r;
    s25 = S25W'(s_r) * S25W'(MID_SCALE);
    far3_nxt = s25 > S25W'(mx);
    zero3_nxt = (len1_r == '0) || (len2_r == '0);
    adot_nxt = dot_r[2*W+1] ? L'(-dot_r) : L'(dot_r);
  end

  always_comb begin
    dsq_nxt = PW'(adot_r) * PW'(adot_r);
    lp_nxt  = PW'(l1_3_r) * PW'(l2_3_r);
    qlo_nxt = HW'(lp_r[L-1:0]) * HW'(COS2_Q20);
    qhi_nxt = HW'(lp_r[PW-1:L]) * HW'(COS2_Q20);
  end

  always_comb begin
    lhs6 = {dsq5_r, {Q_BITS{1'b0}}};
    rhs6 = {qhi_r, {L{1'b0}}} + QW'(qlo_r);
    angle_lt = lhs6 < rhs6;
    if (near5_r) begin
      res_nxt = '{similar: 1'b1, deciding_rule: RULE_NEAR};
    end else if (!zero5_r && angle_lt) begin
      res_nxt = '{similar: 1'b0, deciding_rule: RULE_ANGLE};
    end else if (far5_r) begin
      res_nxt = '{similar: 1'b0, deciding_rule: RULE_FAR};
    end else begin
      res_nxt = '{similar: 1'b1, deciding_rule: RULE_PASS};
    end
  end

  assign v_nxt = {v_r[4:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dxa_r <= dxa_nxt;
    dya_r <= dya_nxt;
    dxb_r <= dxb_nxt;
    dyb_r <= dyb_nxt;
    ex_r  <= ex_nxt;
    ey_r  <= ey_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;

    len1_r <= len1_nxt;
    len2_r <= len2_nxt;
    d_r    <= d_nxt;
    dot_r  <= dot_nxt;
    s_r    <= s_nxt;

    near3_r <= near3_nxt;
    far3_r  <= far3_nxt;
    zero3_r <= zero3_nxt;
    adot_r  <= adot_nxt;
    l1_3_r  <= len1_r;
    l2_3_r  <= len2_r;

    near4_r <= near3_r;
    far4_r  <= far3_r;
    zero4_r <= zero3_r;
    dsq_r   <= dsq_nxt;
    lp_r    <= lp_nxt;

    near5_r <= near4_r;
    far5_r  <= far4_r;
    zero5_r <= zero4_r;
    dsq5_r  <= dsq_r;
    qlo_r   <= qlo_nxt;
    qhi_r   <= qhi_nxt;

    res_r <= res_nxt;
  end

  assign out_valid = v_r[5];
  assign out_res   = res_r;

endmodule

FILE: tb/sv/tb.sv
// testbench for the line segment similarity test: directed and random pairs, checked
`timescale 1ns / 1ps

module tb
  import lsst_pkg::*;
();

  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE_WAIT  = 16;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  seg_pair_t in_seg;
  logic      out_valid;
  sim_res_t  out_res;

  sim_res_t expected_verdicts[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;

  line_segment_similarity_test dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_seg    (in_seg),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint sq_len(input longint x0, input longint y0,
                                    input longint x1, input longint y1);
    return (x1 - x0) * (x1 - x0) + (y1 - y0) * (y1 - y0);
  endfunction

  function automatic sim_res_t predict_verdict(input seg_pair_t p);
    longint      ax[2];
    longint      ay[2];
    longint      bx[2];
    longint      by[2];
    longint      len_a;
    longint      len_b;
    longint      dot;
    longint      sx;
    longint      sy;
    longint      mid_sq;
    longint      len_max;
    logic [127:0] dot_term;
    logic [127:0] cos_term;
    bit          near;
    sim_res_t    r;
    ax[0] = p.a_start_x; ay[0] = p.a_start_y;
    ax[1] = p.a_end_x;   ay[1] = p.a_end_y;
    bx[0] = p.b_start_x; by[0] = p.b_start_y;
    bx[1] = p.b_end_x;   by[1] = p.b_end_y;
    len_a = sq_len(ax[0], ay[0], ax[1], ay[1]);
    len_b = sq_len(bx[0], by[0], bx[1], by[1]);
    near = 1'b0;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (100 * sq_len(ax[i], ay[i], bx[j], by[j]) <= len_a)
          near = 1'b1;
    if (near) begin
      r.similar = 1'b1;
      r.deciding_rule = RULE_NEAR;
      return r;
    end
    if (len_a != 0 && len_b != 0) begin
      dot = (ax[1] - ax[0]) * (bx[1] - bx[0]) + (ay[1] - ay[0]) * (by[1] - by[0]);
      if (dot < 0)
        dot = -dot;
      dot_term = (128'(dot) * 128'(dot)) << Q_BITS;
      cos_term = 128'(len_a) * 128'(len_b) * 128'(COS2_Q20);
      if (dot_term < cos_term) begin
        r.similar = 1'b0;
        r.deciding_rule = RULE_ANGLE;
        return r;
      end
    end
    sx = (ax[0] + ax[1]) - (bx[0] + bx[1]);
    sy = (ay[0] + ay[1]) - (by[0] + by[1]);
    mid_sq = sx * sx + sy * sy;
    len_max = (len_a > len_b) ? len_a : len_b;
    if (25 * mid_sq > len_max) begin
      r.similar = 1'b0;
      r.deciding_rule = RULE_FAR;
    end else begin
      r.similar = 1'b1;
      r.deciding_rule = RULE_PASS;
    end
    return r;
  endfunction

  function automatic seg_pair_t make_pair(input int ax0, input int ay0, input int ax1,
                                          input int ay1, input int bx0, input int by0,
                                          input int bx1, input int by1);
    seg_pair_t p;
    p.a_start_x = coord_t'(ax0); p.a_start_y = coord_t'(ay0);
    p.a_end_x   = coord_t'(ax1); p.a_end_y   = coord_t'(ay1);
    p.b_start_x = coord_t'(bx0); p.b_start_y = coord_t'(by0);
    p.b_end_x   = coord_t'(bx1); p.b_end_y   = coord_t'(by1);
    return p;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0)
      return 0;
    if (v > COORD_MAX)
      return COORD_MAX;
    return v;
  endfunction

  function automatic int pick_coord(input int flavor);
    int sel;
    sel = int'($urandom_range(0, 2));
    case (flavor)
      1: begin
        return int'($urandom_range(0, 7));
      end
      2: begin
        if (sel == 0)
          return 0;
        else if (sel == 1)
          return COORD_MAX;
        return int'($urandom_range(0, COORD_MAX));
      end
      default: begin
        return int'($urandom_range(0, COORD_MAX));
      end
    endcase
  endfunction

  // point at fraction t/1024 along segment A, with jitter
  function automatic int along(input int c0, input int c1, input int t, input int jit);
    return clamp_coord(c0 + ((c1 - c0) * t) / 1024 + int'($urandom_range(0, 2 * jit)) - jit);
  endfunction

  function automatic seg_pair_t random_pair();
    int kind;
    int span;
    int jit;
    int t0;
    int t1;
    int ax0, ay0, ax1, ay1;
    kind = int'($urandom_range(0, 9));
    if (kind < 4)
      return make_pair(pick_coord(kind), pick_coord(kind), pick_coord(kind), pick_coord(kind),
                       pick_coord(kind), pick_coord(kind), pick_coord(kind), pick_coord(kind));
    case ($urandom_range(0, 3))
      0: span = 16;
      1: span = 256;
      2: span = 1024;
      default: span = COORD_MAX;
    endcase
    ax0 = pick_coord(0);
    ay0 = pick_coord(0);
    ax1 = clamp_coord(ax0 + int'($urandom_range(0, 2 * span)) - span);
    ay1 = clamp_coord(ay0 + int'($urandom_range(0, 2 * span)) - span);
    jit = int'($urandom_range(0, (span >> 3) + 2));
    t0 = int'($urandom_range(0, 1536)) - 256;
    t1 = int'($urandom_range(0, 1536)) - 256;
    return make_pair(ax0, ay0, ax1, ay1, along(ax0, ax1, t0, jit), along(ay0, ay1, t0, jit),
                     along(ax0, ax1, t1, jit), along(ay0, ay1, t1, jit));
  endfunction

  task automatic send_pair(input seg_pair_t p);
    start <= 1'b1;
    in_seg <= p;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    expected_verdicts.insert(expected_verdicts.size(), predict_verdict(p));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    sim_res_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t unexpected result: expected none, got similar %0d rule %0d",
                 $time, out_res.similar, out_res.deciding_rule);
        mismatch_count++;
      end else begin
        exp_res = expected_verdicts.pop_front();
        if (out_res.similar !== exp_res.similar) begin
          $display("%0t similar: expected %0d, got %0d",
                   $time, exp_res.similar, out_res.similar);
          mismatch_count++;
        end
        if (out_res.deciding_rule !== exp_res.deciding_rule) begin
          $display("%0t deciding_rule: expected %0d, got %0d",
                   $time, exp_res.deciding_rule, out_res.deciding_rule);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_pair(make_pair(0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
    send_pair(make_pair(0, 0, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX));
    send_pair(make_pair(0, COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0, 0));
    send_pair(make_pair(0, 0, COORD_MAX, 0, 2048, 100, 2048, 4000));
    idle_cycles(3);
  endtask

  task automatic test_zero_length();
    send_pair(make_pair(500, 500, 500, 500, 500, 500, 600, 600));
    send_pair(make_pair(500, 500, 500, 500, 510, 500, 600, 600));
    send_pair(make_pair(550, 550, 550, 550, 500, 500, 600, 600));
    send_pair(make_pair(0, 0, 1000, 0, 500, 300, 500, 300));
    send_pair(make_pair(0, 0, 1000, 0, 500, 10, 500, 10));
    send_pair(make_pair(0, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    idle_cycles(2);
  endtask

  task automatic test_thresholds();
    // endpoint distance exactly a tenth of the length, then just beyond, then a shorter segment inside
    send_pair(make_pair(0, 0, 1000, 0, 1100, 0, 2000, 0));
    send_pair(make_pair(0, 0, 1000, 0, 1101, 0, 2000, 0));
    send_pair(make_pair(0, 0, 1000, 0, 200, 0, 800, 0));
    // midpoint offset on the limit, then one past it
    send_pair(make_pair(0, 0, 1000, 0, 150, 100, 850, 100));
    send_pair(make_pair(0, 0, 1000, 0, 150, 101, 850, 100));
    // angles around six degrees
    send_pair(make_pair(0, 0, 1000, 0, 200, 0, 800, 62));
    send_pair(make_pair(0, 0, 1000, 0, 200, 0, 800, 63));
    send_pair(make_pair(0, 0, 1000, 0, 200, 0, 800, 64));
    send_pair(make_pair(1000, 0, 0, 0, 200, 0, 800, 66));
    idle_cycles(1);
  endtask

  task automatic test_random();
    int sent;
    int burst;
    bit drained;
    sent = 0;
    drained = 1'b0;
    // one long stretch without gaps
    repeat (60) begin
      send_pair(random_pair());
      sent++;
    end
    while (sent < RANDOM_ITEMS) begin
      burst = int'($urandom_range(1, 24));
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_pair(random_pair());
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_cycles(($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 30))
                                                : int'($urandom_range(1, 6)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_seg = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_length();
    test_thresholds();
    test_random();
    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/lsst_pkg.sv
design/line_segment_similarity_test.sv
tb/sv/tb.sv
